/* design/toy_isa_instruction_executor_assert.svh */
// Assertion macros used by the checker file tie_checker.sv.
`ifndef TOY_ISA_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define TOY_ISA_INSTRUCTION_EXECUTOR_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define TIE_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define TIE_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/tie_pkg.sv */
`default_nettype none

package tie_pkg;

  localparam int unsigned REG_COUNT = 8;

  typedef logic [15:0] word_t;
  typedef logic [2:0]  ridx_t;

  typedef enum logic [6:0] {
    OP_ADD = 7'd0,
    OP_ADI = 7'd1,
    OP_BRZ = 7'd2,
    OP_HLT = 7'd3,
    OP_JMP = 7'd4,
    OP_LD  = 7'd5,
    OP_LDI = 7'd6,
    OP_SET = 7'd7,
    OP_SHL = 7'd8,
    OP_ST  = 7'd9,
    OP_SUB = 7'd10
  } opcode_e;

  typedef enum logic [1:0] {
    ST_EXEC   = 2'd0,
    ST_HALT   = 2'd1,
    ST_UNIMPL = 2'd2
  } status_e;

  typedef struct packed {
    logic [6:0] opc;
    ridx_t      f1;
    ridx_t      f2;
    ridx_t      f3;
  } instr_t;

  typedef struct packed {
    word_t instr;
    word_t following_word;
  } in_item_t;

  typedef struct packed {
    status_e status;
    word_t   next_pc;
    logic    reg_written;
    ridx_t   reg_index;
    word_t   reg_value;
    logic    mem_written;
    word_t   mem_address;
    word_t   mem_value;
  } out_item_t;

endpackage

`default_nettype wire

/* design/tie_stream_if.sv */
`default_nettype none

interface tie_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* design/toy_isa_instruction_executor.sv */
`default_nettype none
// Channel  Port   Role    Payload
// input    in_i   sink    in_item_t  : instr, following_word
// result   res_o  source  out_item_t : status, next_pc, reg_*, mem_*
//
// One instruction per cycle sustained while res_o does not stall; a transaction
// goes to the input register, its one-pass result to the result register.
// Register file reads are issued as the transaction is taken; data memory reads
// go out as a load leaves the input register, so load data reaches reg_value
// straight from the memory read register.
// After reset in_i.ready stays low while data memory is zeroed one word per
// cycle. A stall on res_o holds the result, then the input register, then
// in_i.ready.

module toy_isa_instruction_executor import tie_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 4096
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  tie_stream_if.sink    in_i,
  tie_stream_if.source  res_o
);

  localparam int unsigned     AW       = $clog2(DATA_DEPTH);
  localparam bit              POW2     = ((DATA_DEPTH & (DATA_DEPTH - 1)) == 0);
  localparam int unsigned     SH       = 16 + AW;
  localparam longint unsigned RECIP    = ((64'd1 << SH) + 64'(DATA_DEPTH) - 64'd1)
                                         / 64'(DATA_DEPTH);
  localparam logic [AW-1:0]   CLR_LAST = AW'(DATA_DEPTH - 1);

  typedef enum logic [1:0] {
    SRC_RF  = 2'd0,
    SRC_BYP = 2'd1,
    SRC_LD  = 2'd2
  } src_e;

  typedef struct packed {
    src_e  src;
    word_t val;
  } fwd_t;

  // address modulo DATA_DEPTH: mask, or exact reciprocal multiply otherwise
  function automatic logic [AW-1:0] slot(input word_t addr);
    logic [33:0] prod;
    logic [15:0] quo;
    logic [31:0] back;
    logic [16:0] rem;
    if (POW2) begin
      return addr[AW-1:0];
    end
    prod = 34'(addr) * 34'(RECIP);
    quo  = 16'(prod >> SH);
    back = 32'(quo) * 32'(DATA_DEPTH);
    rem  = 17'(addr) - 17'(back);
    if (rem >= 17'(DATA_DEPTH)) begin
      rem = rem - 17'(DATA_DEPTH);
    end
    return AW'(rem);
  endfunction

  function automatic fwd_t fwd_pick(input ridx_t idx, input logic s1_hit,
                                    input ridx_t s1_idx, input logic s1_ld,
                                    input word_t s1_val, input logic wb_hit,
                                    input ridx_t wb_idx, input word_t wb_val,
                                    input logic vld);
    fwd_t f;
    f.src = SRC_RF;
    f.val = '0;
    if (s1_hit && (s1_idx == idx)) begin
      if (s1_ld) begin
        f.src = SRC_LD;
      end else begin
        f.src = SRC_BYP;
        f.val = s1_val;
      end
    end else if (wb_hit && (wb_idx == idx)) begin
      f.src = SRC_BYP;
      f.val = wb_val;
    end else if (!vld) begin
      f.src = SRC_BYP;  // never written since reset: reads as zero
    end
    return f;
  endfunction

  // input register
  logic      s1_valid_q;
  in_item_t  s1_item_q;
  src_e      a_src_q, b_src_q;
  word_t     a_byp_q, b_byp_q;
  // result register
  logic      s2_valid_q;
  out_item_t s2_q;
  logic      s2_ld_q;
  // register file write-back
  logic      wb_valid_q;
  ridx_t     wb_idx_q;
  word_t     wb_val_q;
  logic      wb_ld_q;
  logic [REG_COUNT-1:0] rf_vld_q;
  // architectural pc and memory clear
  word_t     pc_q;
  logic      clr_q;
  logic [AW-1:0] clr_cnt_q;

  logic      accept, s1_adv, in_ready;
  instr_t    in_ins;
  ridx_t     addr_a, addr_b;
  fwd_t      fwd_a, fwd_b;
  word_t     rf_a_rdata, rf_b_rdata, dmem_rdata;
  word_t     wb_data, opa, opb;
  out_item_t alu_res, res_item;
  logic      alu_ld;
  logic      dmem_we;
  logic [AW-1:0] dmem_waddr;
  word_t     dmem_wdata;

  assign s1_adv   = s1_valid_q && (!s2_valid_q || res_o.ready);
  assign in_ready = !clr_q && (!s1_valid_q || s1_adv);
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  assign in_ins  = instr_t'(in_i.payload.instr);
  assign addr_a  = in_ins.f2;
  assign addr_b  = (in_ins.opc == OP_ST) ? in_ins.f1 : in_ins.f3;
  assign wb_data = wb_ld_q ? dmem_rdata : wb_val_q;

  // resolve writes still in flight when the register file is read
  assign fwd_a = fwd_pick(addr_a, s1_adv && alu_res.reg_written, alu_res.reg_index,
                          alu_ld, alu_res.reg_value, wb_valid_q, wb_idx_q, wb_data,
                          rf_vld_q[addr_a]);
  assign fwd_b = fwd_pick(addr_b, s1_adv && alu_res.reg_written, alu_res.reg_index,
                          alu_ld, alu_res.reg_value, wb_valid_q, wb_idx_q, wb_data,
                          rf_vld_q[addr_b]);

  always_comb begin
    case (a_src_q)
      SRC_BYP: opa = a_byp_q;
      SRC_LD:  opa = dmem_rdata;
      default: opa = rf_a_rdata;
    endcase
    case (b_src_q)
      SRC_BYP: opb = b_byp_q;
      SRC_LD:  opb = dmem_rdata;
      default: opb = rf_b_rdata;
    endcase
  end

  tie_alu u_alu (
    .item_i  (s1_item_q),
    .pc_i    (pc_q),
    .opa_i   (opa),
    .opb_i   (opb),
    .res_o   (alu_res),
    .is_ld_o (alu_ld)
  );

  // register file, one copy per read port
  tie_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_a (
    .clk_i   (clk_i),
    .we_i    (wb_valid_q),
    .waddr_i (wb_idx_q),
    .wdata_i (wb_data),
    .re_i    (accept),
    .raddr_i (addr_a),
    .rdata_o (rf_a_rdata)
  );

  tie_ram #(.WIDTH(16), .DEPTH(REG_COUNT)) u_rf_b (
    .clk_i   (clk_i),
    .we_i    (wb_valid_q),
    .waddr_i (wb_idx_q),
    .wdata_i (wb_data),
    .re_i    (accept),
    .raddr_i (addr_b),
    .rdata_o (rf_b_rdata)
  );

  assign dmem_we    = clr_q || (s1_adv && alu_res.mem_written);
  assign dmem_waddr = clr_q ? clr_cnt_q : slot(alu_res.mem_address);
  assign dmem_wdata = clr_q ? '0 : alu_res.mem_value;

  tie_ram #(.WIDTH(16), .DEPTH(DATA_DEPTH)) u_dmem (
    .clk_i   (clk_i),
    .we_i    (dmem_we),
    .waddr_i (dmem_waddr),
    .wdata_i (dmem_wdata),
    .re_i    (s1_adv && alu_ld),
    .raddr_i (slot(opa)),
    .rdata_o (dmem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      wb_valid_q <= 1'b0;
      rf_vld_q   <= '0;
      pc_q       <= '0;
      clr_q      <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_valid_q <= 1'b1;
        pc_q       <= alu_res.next_pc;
      end else if (res_o.ready) begin
        s2_valid_q <= 1'b0;
      end
      wb_valid_q <= s1_adv && alu_res.reg_written;
      if (wb_valid_q) begin
        rf_vld_q[wb_idx_q] <= 1'b1;
      end
      if (clr_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == CLR_LAST) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q <= in_i.payload;
      a_src_q   <= fwd_a.src;
      a_byp_q   <= fwd_a.val;
      b_src_q   <= fwd_b.src;
      b_byp_q   <= fwd_b.val;
    end
    if (s1_adv) begin
      s2_q     <= alu_res;
      s2_ld_q  <= alu_ld;
      wb_idx_q <= alu_res.reg_index;
      wb_val_q <= alu_res.reg_value;
      wb_ld_q  <= alu_ld;
    end
  end

  always_comb begin
    res_item = s2_q;
    if (s2_ld_q) begin
      res_item.reg_value = dmem_rdata;
    end
  end

  assign res_o.valid   = s2_valid_q;
  assign res_o.payload = res_item;

endmodule

`default_nettype wire

/* design/tie_ram.sv */
`default_nettype none

module tie_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/tie_alu.sv */
`default_nettype none

module tie_alu import tie_pkg::*; (
  input  wire in_item_t  item_i,
  input  wire word_t     pc_i,
  input  wire word_t     opa_i,    // R[f2]
  input  wire word_t     opb_i,    // R[f1] for a store, R[f3] otherwise
  output out_item_t      res_o,
  output logic           is_ld_o
);

  instr_t  ins;
  opcode_e op;
  word_t   pc_inc;

  assign ins    = instr_t'(item_i.instr);
  assign op     = opcode_e'(ins.opc);
  assign pc_inc = pc_i + 16'd1;

  always_comb begin
    res_o         = '0;
    res_o.status  = ST_EXEC;
    res_o.next_pc = pc_i;
    is_ld_o       = 1'b0;
    unique case (op)
      OP_ADD: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = opa_i + opb_i;
        res_o.next_pc     = pc_inc;
      end
      OP_ADI: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = opa_i + {13'b0, ins.f3};
        res_o.next_pc     = pc_inc;
      end
      OP_BRZ: begin
        res_o.next_pc = (opa_i == '0) ? pc_i + {10'b0, ins.f1, ins.f3} : pc_inc;
      end
      OP_HLT: begin
        res_o.status = ST_HALT;
      end
      OP_JMP: begin
        res_o.next_pc = opa_i;
      end
      OP_LD: begin
        // value comes from the data memory read register, not from this unit
        res_o.reg_written = 1'b1;
        res_o.next_pc     = pc_inc;
        is_ld_o           = 1'b1;
      end
      OP_LDI: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = {13'b0, ins.f3};
        res_o.next_pc     = pc_inc;
      end
      OP_SET: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = item_i.following_word;
        res_o.next_pc     = pc_i + 16'd2;
      end
      OP_SHL: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = {opb_i[14:0], 1'b0};
        res_o.next_pc     = pc_inc;
      end
      OP_ST: begin
        res_o.mem_written = 1'b1;
        res_o.mem_address = opb_i;
        res_o.mem_value   = opa_i;
        res_o.next_pc     = pc_inc;
      end
      OP_SUB: begin
        res_o.reg_written = 1'b1;
        res_o.reg_value   = opa_i - opb_i;
        res_o.next_pc     = pc_inc;
      end
      default: begin
        res_o.status = ST_UNIMPL;
      end
    endcase
    if (res_o.reg_written) begin
      res_o.reg_index = ins.f1;
    end
  end

endmodule

`default_nettype wire

/* design/tie_checker.sv */
`default_nettype none
`include "toy_isa_instruction_executor_assert.svh"

module tie_checker import tie_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_ready_i,
  input wire logic      out_valid_i,
  input wire logic      out_ready_i,
  input wire out_item_t out_item_i
);

  word_t last_pc_q;

  // track the pc reported by the last delivered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pc_q <= '0;
    end else if (out_valid_i && out_ready_i) begin
      last_pc_q <= out_item_i.next_pc;
    end
  end

  `TIE_ASSERT_NXT(ap_out_hold,
                  out_valid_i && !out_ready_i,
                  out_valid_i && $stable(out_item_i),
                  "result changed while stalled")
  `TIE_ASSERT_IMP(ap_halt_nochange,
                  out_valid_i && (out_item_i.status != ST_EXEC),
                  !out_item_i.reg_written && !out_item_i.mem_written &&
                  (out_item_i.next_pc == last_pc_q),
                  "halt or unknown opcode changed state")
  `TIE_ASSERT_IMP(ap_store_only,
                  out_valid_i && out_item_i.mem_written,
                  !out_item_i.reg_written && (out_item_i.status == ST_EXEC),
                  "store also wrote a register")
  `TIE_ASSERT_IMP(ap_idle_fields,
                  out_valid_i && !out_item_i.reg_written && !out_item_i.mem_written,
                  (out_item_i.reg_index == 3'd0) && (out_item_i.reg_value == 16'd0) &&
                  (out_item_i.mem_address == 16'd0) && (out_item_i.mem_value == 16'd0),
                  "unused result fields not zero")

  // input transaction taken this cycle
  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;
  `TIE_ASSERT_IMP(ap_in_fire_known,
                  in_fire,
                  !$isunknown(in_valid_i),
                  "input handshake unknown")

endmodule

bind toy_isa_instruction_executor tie_checker u_tie_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_item_i  (res_o.payload)
);

`default_nettype wire

/* dv/exec_result_checker.sv */
`timescale 1ns / 100ps

module exec_result_checker import tie_pkg::*; #(
  parameter int unsigned DATA_DEPTH = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tie_stream_if       in_mon,
  tie_stream_if       res_mon,
  output int unsigned mismatch_count,
  output int unsigned results_pending
);

  word_t     pc_model;
  word_t     reg_model [REG_COUNT];
  word_t     mem_model [DATA_DEPTH];
  out_item_t expected_effects [$];

  assign results_pending = expected_effects.size();

  // Execute one instruction against the shadow machine state.
  function automatic out_item_t execute_instr(in_item_t item);
    instr_t    ins;
    word_t     a;
    word_t     b;
    out_item_t r;
    ins = instr_t'(item.instr);
    a = reg_model[ins.f2];
    b = reg_model[ins.f3];
    r = '0;
    r.status = ST_EXEC;
    r.next_pc = pc_model + 16'd1;
    case (ins.opc)
      OP_ADD: begin
        r.reg_written = 1'b1;
        r.reg_value = a + b;
      end
      OP_ADI: begin
        r.reg_written = 1'b1;
        r.reg_value = a + {13'd0, ins.f3};
      end
      OP_BRZ: begin
        if (a == '0) r.next_pc = pc_model + {10'd0, ins.f1, ins.f3};
      end
      OP_HLT: begin
        r.status = ST_HALT;
        r.next_pc = pc_model;
      end
      OP_JMP: begin
        r.next_pc = a;
      end
      OP_LD: begin
        r.reg_written = 1'b1;
        r.reg_value = mem_model[a % DATA_DEPTH];
      end
      OP_LDI: begin
        r.reg_written = 1'b1;
        r.reg_value = {13'd0, ins.f3};
      end
      OP_SET: begin
        r.reg_written = 1'b1;
        r.reg_value = item.following_word;
        r.next_pc = pc_model + 16'd2;
      end
      OP_SHL: begin
        r.reg_written = 1'b1;
        r.reg_value = {b[14:0], 1'b0};
      end
      OP_ST: begin
        r.mem_written = 1'b1;
        r.mem_address = reg_model[ins.f1];
        r.mem_value = a;
        mem_model[r.mem_address % DATA_DEPTH] = a;
      end
      OP_SUB: begin
        r.reg_written = 1'b1;
        r.reg_value = a - b;
      end
      default: begin
        r.status = ST_UNIMPL;
        r.next_pc = pc_model;
      end
    endcase
    if (r.reg_written) begin
      r.reg_index = ins.f1;
      reg_model[ins.f1] = r.reg_value;
    end
    pc_model = r.next_pc;
    return r;
  endfunction

  task automatic check_field(string field, logic [15:0] exp_v, logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, field, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp_r;
    out_item_t act_r;
    if (!rst_ni) begin
      pc_model = '0;
      foreach (reg_model[i]) reg_model[i] = '0;
      foreach (mem_model[i]) mem_model[i] = '0;
      expected_effects.delete();
      mismatch_count = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) expected_effects.push_back(execute_instr(in_mon.payload));
      if (res_mon.valid && res_mon.ready) begin
        act_r = res_mon.payload;
        if (expected_effects.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, act_r);
          mismatch_count++;
        end else begin
          exp_r = expected_effects.pop_front();
          check_field("status", {14'd0, exp_r.status}, {14'd0, act_r.status});
          check_field("next_pc", exp_r.next_pc, act_r.next_pc);
          check_field("reg_written", {15'd0, exp_r.reg_written}, {15'd0, act_r.reg_written});
          check_field("reg_index", {13'd0, exp_r.reg_index}, {13'd0, act_r.reg_index});
          check_field("reg_value", exp_r.reg_value, act_r.reg_value);
          check_field("mem_written", {15'd0, exp_r.mem_written}, {15'd0, act_r.mem_written});
          check_field("mem_address", exp_r.mem_address, act_r.mem_address);
          check_field("mem_value", exp_r.mem_value, act_r.mem_value);
        end
      end
    end
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import tie_pkg::*;

  localparam int unsigned DATA_DEPTH     = 4096;
  localparam int unsigned RANDOM_ITEMS   = 1200;
  localparam logic [6:0]  OP_FIRST_UNUSED = 7'd11;
  localparam logic [6:0]  OP_LAST_UNUSED  = 7'd127;

  logic        clk_i;
  logic        rst_ni;
  logic        idle_on;
  int unsigned mismatch_count;
  int unsigned results_pending;

  tie_stream_if #(.T(in_item_t))  in_ch ();
  tie_stream_if #(.T(out_item_t)) res_ch ();

  toy_isa_instruction_executor #(.DATA_DEPTH(DATA_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  exec_result_checker #(.DATA_DEPTH(DATA_DEPTH)) checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_ch),
    .res_mon         (res_ch),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    res_ch.ready <= !(idle_on && $urandom_range(0, 99) < 32);
  end

  function automatic word_t encode(logic [6:0] opc, ridx_t f1, ridx_t f2, ridx_t f3);
    return {opc, f1, f2, f3};
  endfunction

  // Hold the transaction until the executor takes it.
  task automatic send(word_t instr_w, word_t literal);
    while (idle_on && $urandom_range(0, 99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.payload <= in_item_t'{instr_w, literal};
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_random();
    int unsigned pick;
    logic [6:0]  opc;
    word_t       literal;
    pick = $urandom_range(0, 99);
    if (pick < 8) opc = 7'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
    else if (pick < 11) opc = OP_HLT;
    else opc = 7'($urandom_range(OP_ADD, OP_SUB));
    // Favor small addresses so stores and loads hit the same words.
    case ($urandom_range(0, 3))
      0: literal = 16'($urandom_range(0, 15));
      1: literal = {4'($urandom_range(1, 15)), 8'd0, 4'($urandom_range(0, 15))};
      default: literal = 16'($urandom);
    endcase
    send({opc, 9'($urandom)}, literal);
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (results_pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    idle_on = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    res_ch.ready = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    send(encode(OP_LDI, 1, 0, 7), 16'h0000);
    send(encode(OP_SET, 2, 0, 0), 16'hFFFF);
    send(encode(OP_SET, 3, 0, 0), 16'h8001);
    send(encode(OP_ADD, 4, 2, 3), 16'h0000);
    send(encode(OP_ADI, 5, 2, 7), 16'h0000);
    send(encode(OP_SUB, 6, 0, 1), 16'h0000);
    send(encode(OP_SHL, 7, 0, 3), 16'h0000);
    send(encode(OP_ST, 2, 3, 0), 16'h0000);
    send(encode(OP_LD, 4, 2, 0), 16'h0000);
    send(encode(OP_ST, 1, 5, 0), 16'h0000);
    send(encode(OP_SET, 6, 0, 0), 16'h1007);
    // Address aliases onto the word stored just before.
    send(encode(OP_LD, 0, 6, 0), 16'h0000);
    send(encode(OP_LD, 5, 3, 0), 16'h0000);
    send(encode(OP_BRZ, 7, 5, 7), 16'h0000);
    send(encode(OP_BRZ, 0, 5, 0), 16'h0000);
    send(encode(OP_BRZ, 7, 2, 7), 16'h0000);
    // Jump to the top of the address space and wrap the pc.
    send(encode(OP_JMP, 0, 2, 0), 16'h0000);
    send(encode(OP_SET, 3, 0, 0), 16'h0000);
    send(encode(OP_JMP, 0, 2, 0), 16'h0000);
    send(encode(OP_ADD, 0, 1, 1), 16'h0000);
    send(encode(OP_HLT, 7, 7, 7), 16'hFFFF);
    send({OP_FIRST_UNUSED, 9'd0}, 16'h0000);
    send({OP_LAST_UNUSED, 9'h1FF}, 16'hFFFF);
    send(encode(OP_ADI, 0, 0, 0), 16'h0000);
    in_ch.valid <= 1'b0;
    drain();

    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      idle_on <= !(i >= 400 && i < 600);
      send_random();
    end
    in_ch.valid <= 1'b0;
    idle_on <= 1'b1;
    drain();
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
